>>> rtl/top_k_select_with_index_assert.svh
`ifndef TOP_K_SELECT_WITH_INDEX_ASSERT_SVH
`define TOP_K_SELECT_WITH_INDEX_ASSERT_SVH
// implication check, clocked on aclk, off in reset
`define TKS_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) \
        else $error("%m: lbl");
// next-cycle implication check
`define TKS_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) \
        else $error("%m: lbl");
`endif

>>> rtl/tks_pkg.sv
`default_nettype none
package tks_pkg;
    localparam int MAX_K = 16;
    localparam int MAX_ROW = 65536;
    localparam int KW = $clog2(MAX_K + 1);
    localparam logic [15:0] POS_CAP = (MAX_ROW - 1 < 65535) ? 16'(MAX_ROW - 1) : 16'hFFFF;

    typedef enum logic [0:0] {ST_COLLECT, ST_DRAIN} state_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] value;
        logic [31:0] key;
        logic [15:0] position;
    } slot_t;

    typedef struct packed {
        logic        ins;
        logic [31:0] value;
        logic [31:0] key;
        logic [15:0] position;
        logic        shift;
        logic        clear;
    } cell_ctl_t;

    function automatic logic [31:0] order_key(input logic [31:0] b);
        logic [31:0] r;
        if (b[30:0] == 31'd0) r = 32'h8000_0000;
        else if (b[31]) r = ~b;
        else r = b | 32'h8000_0000;
        return r;
    endfunction

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction
endpackage
`default_nettype wire

>>> rtl/tks_cell.sv
`default_nettype none
module tks_cell import tks_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire cell_ctl_t ctl,
    input  wire logic      enable,
    input  wire logic      prev_wins,
    input  wire slot_t     prev_slot,
    input  wire slot_t     next_slot,
    output slot_t          slot,
    output logic           wins
);
    slot_t slot_reg, slot_next;

    assign wins = ctl.ins && enable && (!slot_reg.valid || ctl.key > slot_reg.key);
    assign slot = slot_reg;

    always_comb begin
        slot_next = slot_reg;
        if (ctl.clear) begin
            slot_next.valid = 1'b0;
        end else if (ctl.shift) begin
            slot_next = next_slot;
        end else if (prev_wins && enable) begin
            slot_next = prev_slot;
        end else if (wins) begin
            slot_next.valid    = 1'b1;
            slot_next.value    = ctl.value;
            slot_next.key      = ctl.key;
            slot_next.position = ctl.position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end else begin
            slot_reg.valid <= slot_next.valid;
        end
        slot_reg.value    <= slot_next.value;
        slot_reg.key      <= slot_next.key;
        slot_reg.position <= slot_next.position;
    end
endmodule
`default_nettype wire

>>> rtl/top_k_select_with_index.sv
// Input: an element is absorbed at the edge that accepts it; one per cycle while s_ready is high.
// Row end: the cell chain drains its n = min(k, kept) items from the head, one per cycle
// while m_ready allows, then clears its slots; s_ready stays low through the drain and
// the clear, so a new row waits for both.
// Reset: aresetn synchronous active low; clears slots, counter, k back to 1.
`default_nettype none
module top_k_select_with_index import tks_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_value_bits,
    input  wire logic        s_row_end,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_top_value_bits,
    output logic [15:0]      m_top_position,
    output logic             m_run_last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [4:0]  cfg_data
);
    state_t state_reg, state_next;
    logic [4:0]  keep_reg;
    logic [15:0] count_reg;
    logic [KW-1:0] pop_cnt_reg;
    logic [KW-1:0] k_eff;
    cell_ctl_t ctl;
    slot_t slots [MAX_K+1];
    logic  wins  [MAX_K+1];
    logic  s_fire, m_free, pop, drain_done;

    assign cfg_ready = (state_reg == ST_COLLECT);
    assign s_ready   = (state_reg == ST_COLLECT);
    assign s_fire    = s_valid && s_ready;
    assign m_free    = !m_valid || m_ready;
    assign pop       = (state_reg == ST_DRAIN) && m_free && slots[0].valid &&
                       (pop_cnt_reg < k_eff);
    assign drain_done = (state_reg == ST_DRAIN) &&
                        (!slots[0].valid || pop_cnt_reg == k_eff);

    always_comb begin
        if (keep_reg == 5'd0) k_eff = KW'(1);
        else if (32'(keep_reg) > MAX_K) k_eff = KW'(MAX_K);
        else k_eff = KW'(keep_reg);
    end

    always_comb begin
        ctl.ins      = s_fire && !is_nan(s_value_bits);
        ctl.value    = s_value_bits;
        ctl.key      = order_key(s_value_bits);
        ctl.position = count_reg;
        ctl.shift    = pop;
        ctl.clear    = drain_done;
    end

    assign slots[MAX_K] = '0;
    assign wins[MAX_K]  = 1'b0;

    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
        slot_t prev_s;
        logic  prev_w;
        if (i == 0) begin : g_head
            assign prev_s = '0;
            assign prev_w = 1'b0;
        end else begin : g_body
            assign prev_s = slots[i-1];
            assign prev_w = wins[i-1];
        end
        tks_cell u_cell (
            .aclk(aclk), .aresetn(aresetn), .ctl(ctl),
            .enable(KW'(i) < k_eff),
            .prev_wins(prev_w), .prev_slot(prev_s), .next_slot(slots[i+1]),
            .slot(slots[i]), .wins(wins[i])
        );
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: if (s_fire && s_row_end) state_next = ST_DRAIN;
            ST_DRAIN:   if (drain_done) state_next = ST_COLLECT;
            default:    state_next = ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_COLLECT;
            keep_reg    <= 5'd1;
            count_reg   <= '0;
            pop_cnt_reg <= '0;
            m_valid     <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) keep_reg <= cfg_data;
            if (s_fire) begin
                if (s_row_end) count_reg <= '0;
                else if (count_reg < POS_CAP) count_reg <= count_reg + 16'd1;
            end
            if (drain_done) pop_cnt_reg <= '0;
            else if (pop) pop_cnt_reg <= pop_cnt_reg + KW'(1);
            if (pop) m_valid <= 1'b1;
            else if (m_ready) m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_top_value_bits <= slots[0].value;
            m_top_position   <= slots[0].position;
            m_run_last       <= !slots[1].valid || (pop_cnt_reg + KW'(1) == k_eff);
        end
    end
endmodule
`default_nettype wire

>>> rtl/tks_checker.sv
`default_nettype none
`include "top_k_select_with_index_assert.svh"
module tks_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic s_row_end,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_run_last
);
    `TKS_ASSERT_NXT(a_row_end_stalls_input, s_valid && s_ready && s_row_end, !s_ready)
    `TKS_ASSERT_IMP(a_no_input_with_output, m_valid && !m_run_last, !s_ready)
    `TKS_ASSERT_NXT(a_hold_output, m_valid && !m_ready, m_valid)
endmodule
bind top_k_select_with_index tks_checker u_tks_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .s_row_end(s_row_end), .m_valid(m_valid), .m_ready(m_ready),
    .m_run_last(m_run_last)
);
`default_nettype wire

>>> test/tb_top.sv
`default_nettype none
module tb_top;
    import tks_pkg::*;

    typedef struct {
        logic [31:0] value_bits;
        logic        row_end;
    } element_t;

    typedef struct {
        logic [31:0] value_bits;
        logic [15:0] position;
        logic        run_last;
    } pick_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_value_bits = '0;
    logic        s_row_end = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_top_value_bits;
    logic [15:0] m_top_position;
    logic        m_run_last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;

    top_k_select_with_index uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_value_bits(s_value_bits), .s_row_end(s_row_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_top_value_bits(m_top_value_bits), .m_top_position(m_top_position),
        .m_run_last(m_run_last),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    element_t    pending_elements[$];
    pick_t       expected_picks[$];
    logic [31:0] kept_value[MAX_K];
    logic [15:0] kept_position[MAX_K];
    logic        kept_valid[MAX_K];
    int unsigned row_count;
    logic [4:0]  keep_reg;
    int          errors = 0;
    int          cycle_count = 0;
    int          send_gap = 0;
    int          take_gap = 0;
    int          hold_off = 0;
    bit          hold_request = 1'b0;
    bit          stall_receiver = 1'b0;
    bit          gaps_on = 1'b1;
    bit          in_taken = 1'b0;
    bit          out_taken = 1'b0;

    function automatic logic [31:0] sort_key(logic [31:0] b);
        if (b[30:0] == 31'd0) return 32'h8000_0000;
        if (b[31]) return ~b;
        return b | 32'h8000_0000;
    endfunction

    function automatic bit not_a_number(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    task automatic add_element(logic [31:0] v, logic last);
        element_t e;
        e.value_bits = v;
        e.row_end = last;
        pending_elements.insert(pending_elements.size(), e);
    endtask

    task automatic clear_selection();
        for (int i = 0; i < MAX_K; i++) kept_valid[i] = 1'b0;
        row_count = 0;
    endtask

    task automatic predict_selection(element_t e);
        int unsigned k;
        int unsigned pos;
        int unsigned i;
        int unsigned n;
        logic [31:0] key;
        pick_t p;
        k = (keep_reg == 0) ? 1 : (keep_reg > MAX_K ? MAX_K : keep_reg);
        pos = (row_count < POS_CAP) ? row_count : POS_CAP;
        if (!not_a_number(e.value_bits)) begin
            key = sort_key(e.value_bits);
            for (i = 0; i < k; i++)
                if (!kept_valid[i] || key > sort_key(kept_value[i])) break;
            if (i < k) begin
                for (int j = k - 1; j > int'(i); j--) begin
                    kept_value[j] = kept_value[j-1];
                    kept_position[j] = kept_position[j-1];
                    kept_valid[j] = kept_valid[j-1];
                end
                kept_value[i] = e.value_bits;
                kept_position[i] = 16'(pos);
                kept_valid[i] = 1'b1;
            end
        end
        if (row_count < POS_CAP) row_count++;
        if (e.row_end) begin
            n = 0;
            while (n < k && kept_valid[n]) n++;
            for (i = 0; i < n; i++) begin
                p.value_bits = kept_value[i];
                p.position = kept_position[i];
                p.run_last = (i + 1 == n);
                expected_picks.insert(expected_picks.size(), p);
            end
            clear_selection();
        end
    endtask

    task automatic report(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        errors++;
    endtask

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // handshakes seen at the rising edge
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        out_taken <= aresetn && m_valid && m_ready;
    end

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_taken) begin
                predict_selection('{s_value_bits, s_row_end});
                send_gap = gaps_on ? $urandom_range(0, 19) : 0;
            end
            if (!s_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_elements.size() > 0) begin
                    element_t e;
                    e = pending_elements.pop_front();
                    s_value_bits <= e.value_bits;
                    s_row_end <= e.row_end;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(negedge aclk) begin
        if (hold_request && hold_off == 0 && !stall_receiver) begin
            hold_off <= 300;
            stall_receiver <= 1'b1;
        end else if (stall_receiver) begin
            if (hold_off == 1) stall_receiver <= 1'b0;
            hold_off <= hold_off - 1;
        end
    end

    // receiver ready
    always @(negedge aclk) begin
        if (aresetn) begin
            if (out_taken)
                take_gap = gaps_on ? $urandom_range(0, 19) : 0;
            if (stall_receiver) begin
                m_ready <= 1'b0;
            end else if (take_gap > 0) begin
                take_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_picks.size() == 0) begin
                report("unexpected result");
            end else begin
                pick_t p;
                p = expected_picks.pop_front();
                if (m_top_value_bits !== p.value_bits)
                    report($sformatf("value %h, want %h", m_top_value_bits, p.value_bits));
                if (m_top_position !== p.position)
                    report($sformatf("position %0d, want %0d", m_top_position, p.position));
                if (m_run_last !== p.run_last)
                    report($sformatf("run_last %b, want %b", m_run_last, p.run_last));
            end
        end
    end

    task automatic drain_all();
        while (pending_elements.size() > 0 || s_valid || expected_picks.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_keep(logic [4:0] k);
        @(negedge aclk);
        cfg_data <= k;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        keep_reg = k;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_float();
        case ($urandom_range(0, 9))
            0: return 32'h7FC0_0000 | $urandom_range(0, 32'h3F_FFFF);
            1: return {1'($urandom_range(0, 1)), 31'd0};
            2: return {1'($urandom_range(0, 1)), 8'hFF, 23'd0};
            3: return {1'($urandom_range(0, 1)), 31'h3F80_0000};
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_row(int len);
        for (int i = 0; i < len; i++)
            add_element(random_float(), i == len - 1);
    endtask

    initial begin
        keep_reg = 5'd1;
        clear_selection();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed
        write_keep(5'd4);
        add_element(32'h0000_0000, 1'b0);
        add_element(32'h8000_0000, 1'b0);
        add_element(32'h7F80_0000, 1'b0);
        add_element(32'hFF80_0000, 1'b0);
        add_element(32'h7FFF_FFFF, 1'b0);
        add_element(32'hFFFF_FFFF, 1'b0);
        add_element(32'h3F80_0000, 1'b0);
        add_element(32'h3F80_0000, 1'b1);
        add_element(32'h7FC0_0001, 1'b0);
        add_element(32'hFFC0_0000, 1'b1);
        add_element(32'h1234_5678, 1'b1);
        drain_all();
        write_keep(5'd0);
        add_element(32'h4000_0000, 1'b0);
        add_element(32'h4040_0000, 1'b1);
        drain_all();
        write_keep(5'd31);
        for (int i = 0; i < 20; i++)
            add_element(32'(i) << 20, i == 19);
        drain_all();

        // stall the receiver while rows keep coming
        write_keep(5'd16);
        hold_request = 1'b1;
        repeat (3) queue_row(20);
        wait (stall_receiver);
        hold_request = 1'b0;
        drain_all();

        // random rows
        for (int r = 0; r < 5; r++) begin
            write_keep(5'($urandom_range(0, 31)));
            gaps_on = (r % 4 != 3);
            queue_row($urandom_range(1, 12));
            queue_row($urandom_range(1, 12));
            drain_all();
        end

        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
